// ===== hw/rtl/tpg_pkg.sv =====
// Shared types, constants and tables of the trochoid point generator.
`timescale 1ns / 1ps
`default_nettype none

package tpg_pkg;

   // Width of the phase remainder while it runs through the reduction cells
   localparam int REM_W = 62;
   // Width of the CORDIC datapath (Q30 plus headroom)
   localparam int CW = 34;

   // pi with 60 fraction bits
   localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
   // Start value of the CORDIC x register: inverse of the limit gain in Q30
   localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sh26DD3B6A;

   localparam logic signed [63:0] INT32_MAX_64 = 64'sh000000007FFFFFFF;
   localparam logic signed [63:0] INT32_MIN_64 = -64'sh0000000080000000;
   localparam logic signed [31:0] INT32_MAX = 32'sh7FFFFFFF;
   localparam logic signed [31:0] INT32_MIN = 32'sh80000000;

   // Configuration register indexes
   typedef enum logic [2:0] {
      CSR_BASE_RADIUS   = 3'd0,
      CSR_TRACER_RADIUS = 3'd1,
      CSR_X_OFFSET      = 3'd2,
      CSR_Y_OFFSET      = 3'd3,
      CSR_PHASE_OFFSET  = 3'd4,
      CSR_ROTATION_RATE = 3'd5
   } csr_index_type;

   // Side information that travels with each transaction along the cell chains
   typedef struct packed {
      logic               sat;
      logic               neg;
      logic signed [31:0] phase;
   } tag_type;

   // atan(2^-i) in Q30
   function automatic logic [31:0] atan_q30(input int idx);
      logic [31:0] val;
      case (idx)
         0:  val = 32'h3243F6A8;
         1:  val = 32'h1DAC6705;
         2:  val = 32'h0FADBAFC;
         3:  val = 32'h07F56EA6;
         4:  val = 32'h03FEAB76;
         5:  val = 32'h01FFD55B;
         6:  val = 32'h00FFFAAA;
         7:  val = 32'h007FFF55;
         8:  val = 32'h003FFFEA;
         9:  val = 32'h001FFFFD;
         10: val = 32'h000FFFFF;
         11: val = 32'h0007FFFF;
         12: val = 32'h0003FFFF;
         13: val = 32'h0001FFFF;
         14: val = 32'h0000FFFF;
         15: val = 32'h00007FFF;
         16: val = 32'h00003FFF;
         17: val = 32'h00001FFF;
         18: val = 32'h00000FFF;
         19: val = 32'h000007FF;
         20: val = 32'h000003FF;
         21: val = 32'h000001FF;
         22: val = 32'h000000FF;
         23: val = 32'h0000007F;
         24: val = 32'h0000003F;
         25: val = 32'h0000001F;
         26: val = 32'h0000000F;
         27: val = 32'h00000008;
         28: val = 32'h00000004;
         29: val = 32'h00000002;
         30: val = 32'h00000001;
         default: val = 32'h00000000;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tpg_reduce_cell.sv =====
// One step of the modulo-2*pi phase reduction: conditional subtract of a fixed multiple.
`timescale 1ns / 1ps
`default_nettype none

module tpg_reduce_cell #(
   parameter logic [tpg_pkg::REM_W-1:0] SUB = 62'd1
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        advance,
   input  wire logic                        in_valid,
   input  wire logic [tpg_pkg::REM_W-1:0]   in_rem,
   input  wire tpg_pkg::tag_type            in_tag,
   output logic                             out_valid,
   output logic [tpg_pkg::REM_W-1:0]        out_rem,
   output tpg_pkg::tag_type                 out_tag
);

   logic                        valid_ff;
   logic [tpg_pkg::REM_W-1:0]   rem_ff;
   logic [tpg_pkg::REM_W-1:0]   rem_in;
   tpg_pkg::tag_type            tag_ff;

   // Drop this multiple when the remainder still holds it
   always_comb begin
      if (in_rem >= SUB) begin
         rem_in = in_rem - SUB;
      end else begin
         rem_in = in_rem;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff <= rem_in;
         tag_ff <= in_tag;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_tag   = tag_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/tpg_cordic_cell.sv =====
// One CORDIC rotation stage in Q30 with its residual angle.
`timescale 1ns / 1ps
`default_nettype none

module tpg_cordic_cell #(
   parameter int STAGE = 0
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           advance,
   input  wire logic                           in_valid,
   input  wire logic signed [tpg_pkg::CW-1:0]  in_x,
   input  wire logic signed [tpg_pkg::CW-1:0]  in_y,
   input  wire logic signed [tpg_pkg::CW-1:0]  in_z,
   input  wire tpg_pkg::tag_type               in_tag,
   output logic                                out_valid,
   output logic signed [tpg_pkg::CW-1:0]       out_x,
   output logic signed [tpg_pkg::CW-1:0]       out_y,
   output logic signed [tpg_pkg::CW-1:0]       out_z,
   output tpg_pkg::tag_type                    out_tag
);

   localparam logic signed [tpg_pkg::CW-1:0] ANGLE =
      $signed({{(tpg_pkg::CW-32){1'b0}}, tpg_pkg::atan_q30(STAGE)});

   logic                              valid_ff;
   logic signed [tpg_pkg::CW-1:0]     x_ff, y_ff, z_ff;
   logic signed [tpg_pkg::CW-1:0]     x_in, y_in, z_in;
   logic signed [tpg_pkg::CW-1:0]     x_sh, y_sh;
   tpg_pkg::tag_type                  tag_ff;

   // Rotate toward a zero residual; a zero residual counts as positive
   always_comb begin
      x_sh = in_x >>> STAGE;
      y_sh = in_y >>> STAGE;
      if (!in_z[tpg_pkg::CW-1]) begin
         x_in = in_x - y_sh;
         y_in = in_y + x_sh;
         z_in = in_z - ANGLE;
      end else begin
         x_in = in_x + y_sh;
         y_in = in_y - x_sh;
         z_in = in_z + ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         z_ff   <= z_in;
         tag_ff <= in_tag;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;
   assign out_tag   = tag_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/trochoid_point_generator.sv =====
// Top level of the trochoid point generator: phase, reduction chain, CORDIC chain, output math.
`timescale 1ns / 1ps
`default_nettype none

// Evaluates one trochoid point per instant: u = phase_offset + instant*rotation_rate,
// x = x_offset + base_radius*u - tracer_radius*sin(u), y = y_offset - base_radius +
// tracer_radius*cos(u), all signed fixed point with FRAC_BITS fraction bits, results
// clipped to 32 bits with rsp_saturated set when the phase or an output was clipped.
// The datapath is one pipeline that takes a new instant every cycle while it is not
// stalled; it is made of 4 phase stages, (31 - FRAC_BITS) modulo-2*pi cells, 1 quadrant
// fold stage, CORDIC_STAGES rotation cells and 4 output stages. The chain moves on as a
// whole; it stops only when the output register holds an untaken point and the last
// stage carries another one. Registers are written over the csr_ port at any index
// 0..5, other indexes are ignored; csr_ready is always high.
module trochoid_point_generator #(
   parameter int FRAC_BITS     = 16,
   parameter int CORDIC_STAGES = 20
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // input instants
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [31:0] req_instant,
   // curve points
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [31:0]      rsp_point_x,
   output logic signed [31:0]      rsp_point_y,
   output logic                    rsp_saturated,
   // configuration writes
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [2:0]         csr_index,
   input  wire logic [31:0]        csr_data
);

   localparam int REM_W = tpg_pkg::REM_W;
   localparam int CW    = tpg_pkg::CW;

   // pi, 2*pi and pi/2 with FRAC_BITS+28 fraction bits
   localparam logic [63:0] PI_G =
      (tpg_pkg::PI_Q60 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
   localparam logic [63:0] TWO_PI   = PI_G << 1;
   localparam logic [63:0] HALF_PI  = PI_G >> 1;
   localparam logic [63:0] WRAP_LIM = TWO_PI - HALF_PI;
   // Multiple of 2*pi that lifts any scaled phase above zero
   localparam logic [63:0] BIAS = TWO_PI << (30 - FRAC_BITS);
   localparam int RED_STEPS = 31 - FRAC_BITS;

   localparam logic signed [63:0] HALF_LSB = 64'sd1 <<< (FRAC_BITS - 1);
   localparam logic signed [31:0] ONE      = 32'sd1 <<< FRAC_BITS;

   // ------------------------------------------------------------------
   // Configuration registers
   logic signed [31:0] base_radius_ff, tracer_radius_ff, x_offset_ff;
   logic signed [31:0] y_offset_ff, phase_offset_ff, rotation_rate_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_radius_ff   <= ONE;
         tracer_radius_ff <= ONE;
         x_offset_ff      <= '0;
         y_offset_ff      <= '0;
         phase_offset_ff  <= '0;
         rotation_rate_ff <= ONE;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            tpg_pkg::CSR_BASE_RADIUS:   base_radius_ff   <= $signed(csr_data);
            tpg_pkg::CSR_TRACER_RADIUS: tracer_radius_ff <= $signed(csr_data);
            tpg_pkg::CSR_X_OFFSET:      x_offset_ff      <= $signed(csr_data);
            tpg_pkg::CSR_Y_OFFSET:      y_offset_ff      <= $signed(csr_data);
            tpg_pkg::CSR_PHASE_OFFSET:  phase_offset_ff  <= $signed(csr_data);
            tpg_pkg::CSR_ROTATION_RATE: rotation_rate_ff <= $signed(csr_data);
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Flow control: stall only when the output holds a point and the last stage has another
   logic advance;
   logic o3_valid_ff;

   assign advance   = !rsp_valid || rsp_ready || !o3_valid_ff;
   assign req_ready = advance;

   // ------------------------------------------------------------------
   // Phase stages: multiply, round, add offset and clip, scale and bias
   logic               s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic signed [63:0] prod_ff, rnd_ff, phase_sum;
   logic signed [31:0] phase_ff, phase_in;
   logic               phase_sat_ff, phase_sat_in;
   logic signed [63:0] biased;
   logic [REM_W-1:0]   bias_rem_ff;
   tpg_pkg::tag_type   s4_tag_ff;

   always_comb begin
      phase_sum = rnd_ff + 64'(phase_offset_ff);
      if (phase_sum > tpg_pkg::INT32_MAX_64) begin
         phase_in     = tpg_pkg::INT32_MAX;
         phase_sat_in = 1'b1;
      end else if (phase_sum < tpg_pkg::INT32_MIN_64) begin
         phase_in     = tpg_pkg::INT32_MIN;
         phase_sat_in = 1'b1;
      end else begin
         phase_in     = phase_sum[31:0];
         phase_sat_in = 1'b0;
      end
      biased = (64'(phase_ff) <<< 28) + $signed(BIAS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff         <= 64'(req_instant) * 64'(rotation_rate_ff);
         rnd_ff          <= (prod_ff + HALF_LSB) >>> FRAC_BITS;
         phase_ff        <= phase_in;
         phase_sat_ff    <= phase_sat_in;
         bias_rem_ff     <= biased[REM_W-1:0];
         s4_tag_ff.sat   <= phase_sat_ff;
         s4_tag_ff.neg   <= 1'b0;
         s4_tag_ff.phase <= phase_ff;
      end
   end

   // ------------------------------------------------------------------
   // Reduction chain: strip multiples of 2*pi, largest first
   logic             red_valid [0:RED_STEPS];
   logic [REM_W-1:0] red_rem   [0:RED_STEPS];
   tpg_pkg::tag_type red_tag   [0:RED_STEPS];

   assign red_valid[0] = s4_valid_ff;
   assign red_rem[0]   = bias_rem_ff;
   assign red_tag[0]   = s4_tag_ff;

   for (genvar g = 0; g < RED_STEPS; g++) begin : g_reduce
      localparam logic [63:0] SUB_FULL = TWO_PI << (RED_STEPS - 1 - g);
      tpg_reduce_cell #(
         .SUB(SUB_FULL[REM_W-1:0])
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .in_valid (red_valid[g]),
         .in_rem   (red_rem[g]),
         .in_tag   (red_tag[g]),
         .out_valid(red_valid[g+1]),
         .out_rem  (red_rem[g+1]),
         .out_tag  (red_tag[g+1])
      );
   end

   // ------------------------------------------------------------------
   // Fold into [-pi/2, pi/2] and take the angle to Q30
   logic                 fold_valid_ff;
   logic signed [CW-1:0] fold_z_ff;
   tpg_pkg::tag_type     fold_tag_ff, fold_tag_in;
   logic [REM_W-1:0]     rem_end, fold_sub;
   logic signed [REM_W:0] fold_diff, fold_shift;

   always_comb begin
      rem_end     = red_rem[RED_STEPS];
      fold_tag_in = red_tag[RED_STEPS];
      if (rem_end <= HALF_PI[REM_W-1:0]) begin
         fold_sub = '0;
      end else if (rem_end < WRAP_LIM[REM_W-1:0]) begin
         fold_sub        = PI_G[REM_W-1:0];
         fold_tag_in.neg = 1'b1;
      end else begin
         fold_sub = TWO_PI[REM_W-1:0];
      end
      fold_diff  = $signed({1'b0, rem_end}) - $signed({1'b0, fold_sub});
      fold_shift = fold_diff >>> (FRAC_BITS - 2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_valid_ff <= 1'b0;
      end else if (advance) begin
         fold_valid_ff <= red_valid[RED_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         fold_z_ff   <= $signed(fold_shift[CW-1:0]);
         fold_tag_ff <= fold_tag_in;
      end
   end

   // ------------------------------------------------------------------
   // CORDIC chain
   logic                 cor_valid [0:CORDIC_STAGES];
   logic signed [CW-1:0] cor_x     [0:CORDIC_STAGES];
   logic signed [CW-1:0] cor_y     [0:CORDIC_STAGES];
   logic signed [CW-1:0] cor_z     [0:CORDIC_STAGES];
   tpg_pkg::tag_type     cor_tag   [0:CORDIC_STAGES];

   assign cor_valid[0] = fold_valid_ff;
   assign cor_x[0]     = tpg_pkg::CORDIC_GAIN_Q30;
   assign cor_y[0]     = '0;
   assign cor_z[0]     = fold_z_ff;
   assign cor_tag[0]   = fold_tag_ff;

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
      tpg_cordic_cell #(
         .STAGE(i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .in_valid (cor_valid[i]),
         .in_x     (cor_x[i]),
         .in_y     (cor_y[i]),
         .in_z     (cor_z[i]),
         .in_tag   (cor_tag[i]),
         .out_valid(cor_valid[i+1]),
         .out_x    (cor_x[i+1]),
         .out_y    (cor_y[i+1]),
         .out_z    (cor_z[i+1]),
         .out_tag  (cor_tag[i+1])
      );
   end

   // ------------------------------------------------------------------
   // Output stages: sign fix, products, sums, round and clip
   logic                 o1_valid_ff, o2_valid_ff;
   logic signed [31:0]   sin_ff, cos_ff;
   logic signed [CW-1:0] sin_in, cos_in;
   tpg_pkg::tag_type     o1_tag_ff;
   logic signed [63:0]   prod_au_ff, prod_bs_ff, prod_bc_ff;
   logic                 o2_sat_ff, o3_sat_ff;
   logic signed [63:0]   acc_x_ff, acc_y_ff, acc_x_in, acc_y_in;
   logic signed [63:0]   rnd_x, rnd_y;
   logic signed [31:0]   point_x_in, point_y_in;
   logic                 clip_x, clip_y;

   always_comb begin
      if (cor_tag[CORDIC_STAGES].neg) begin
         sin_in = -cor_y[CORDIC_STAGES];
         cos_in = -cor_x[CORDIC_STAGES];
      end else begin
         sin_in = cor_y[CORDIC_STAGES];
         cos_in = cor_x[CORDIC_STAGES];
      end
   end

   always_comb begin
      acc_x_in = prod_au_ff - (prod_bs_ff >>> (30 - FRAC_BITS))
                 + (64'(x_offset_ff) <<< FRAC_BITS);
      acc_y_in = ((64'(y_offset_ff) - 64'(base_radius_ff)) <<< FRAC_BITS)
                 + (prod_bc_ff >>> (30 - FRAC_BITS));
   end

   // Round half up and clip both coordinates
   always_comb begin
      rnd_x = (acc_x_ff + HALF_LSB) >>> FRAC_BITS;
      rnd_y = (acc_y_ff + HALF_LSB) >>> FRAC_BITS;
      clip_x = 1'b1;
      clip_y = 1'b1;
      if (rnd_x > tpg_pkg::INT32_MAX_64) begin
         point_x_in = tpg_pkg::INT32_MAX;
      end else if (rnd_x < tpg_pkg::INT32_MIN_64) begin
         point_x_in = tpg_pkg::INT32_MIN;
      end else begin
         point_x_in = rnd_x[31:0];
         clip_x     = 1'b0;
      end
      if (rnd_y > tpg_pkg::INT32_MAX_64) begin
         point_y_in = tpg_pkg::INT32_MAX;
      end else if (rnd_y < tpg_pkg::INT32_MIN_64) begin
         point_y_in = tpg_pkg::INT32_MIN;
      end else begin
         point_y_in = rnd_y[31:0];
         clip_y     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o1_valid_ff <= 1'b0;
         o2_valid_ff <= 1'b0;
         o3_valid_ff <= 1'b0;
      end else if (advance) begin
         o1_valid_ff <= cor_valid[CORDIC_STAGES];
         o2_valid_ff <= o1_valid_ff;
         o3_valid_ff <= o2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sin_ff     <= sin_in[31:0];
         cos_ff     <= cos_in[31:0];
         o1_tag_ff  <= cor_tag[CORDIC_STAGES];
         prod_au_ff <= 64'(base_radius_ff) * 64'(o1_tag_ff.phase);
         prod_bs_ff <= 64'(tracer_radius_ff) * 64'(sin_ff);
         prod_bc_ff <= 64'(tracer_radius_ff) * 64'(cos_ff);
         o2_sat_ff  <= o1_tag_ff.sat;
         acc_x_ff   <= acc_x_in;
         acc_y_ff   <= acc_y_in;
         o3_sat_ff  <= o2_sat_ff;
      end
   end

   // Output register: load whenever it is empty or being taken
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_ready) begin
         rsp_valid_ff <= o3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || rsp_ready) begin
         rsp_point_x   <= point_x_in;
         rsp_point_y   <= point_y_in;
         rsp_saturated <= o3_sat_ff || clip_x || clip_y;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/tpg_checker.sv =====
// Port-level checks of the trochoid point generator and their binding.
`timescale 1ns / 1ps
`default_nettype none

module tpg_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic signed [31:0] rsp_point_x,
   input wire logic signed [31:0] rsp_point_y,
   input wire logic               rsp_saturated,
   input wire logic               csr_valid,
   input wire logic               csr_ready
);

   // A point that is not taken stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped before the transaction completed");

   // A point that is not taken keeps its value
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_point_x) && $stable(rsp_point_y)
                                  && $stable(rsp_saturated))
      else $error("rsp payload changed while stalled");

   // Reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   // An empty or draining output never blocks new instants
   a_accept_free: assert property (@(posedge clock)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("req_ready low while the output side is free");

   // Configuration writes are always taken
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("csr write not taken");

endmodule

bind trochoid_point_generator tpg_checker u_checker (.*);

`default_nettype wire

// ===== test/trochoid_point_checker.sv =====
// Checker for the trochoid point generator: predicts each point and compares the results.
`timescale 1ns / 1ps

module trochoid_point_checker #(
   parameter int FRAC_BITS     = 16,
   parameter int CORDIC_STAGES = 20
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic signed [31:0] req_instant,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [31:0] rsp_point_x,
   input  logic signed [31:0] rsp_point_y,
   input  logic               rsp_saturated,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data,
   output int                 fail_count,
   output int                 pending_points,
   output int                 checked_points
);

   localparam longint ONE_F        = longint'(1) << FRAC_BITS;
   localparam longint HALF_LSB     = longint'(1) << (FRAC_BITS - 1);
   localparam longint PHASE_TO_G   = longint'(1) << 28;
   localparam longint PI_G         =
      longint'((tpg_pkg::PI_Q60 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));
   localparam longint TWO_PI_G     = 2 * PI_G;
   localparam longint HALF_PI_G    = PI_G >>> 1;
   localparam longint CORDIC_START = 64'sh26DD3B6A;
   localparam longint WORD_MAX     = 64'sh000000007FFFFFFF;
   localparam longint WORD_MIN     = -64'sh0000000080000000;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic               sat;
   } curve_point_type;

   // atan(2^-i) in Q30
   longint atan_table [32] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
      64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
      64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
      64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
      64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
      64'h00000001, 64'h00000000
   };

   // Shadow copy of the curve registers
   longint base_r;
   longint tracer_r;
   longint x_off;
   longint y_off;
   longint phase_off;
   longint rate;

   curve_point_type point_queue [$];
   int fails;
   int checked;

   function automatic longint clip32(input longint v, inout bit flag);
      if (v > WORD_MAX) begin
         flag = 1'b1;
         return WORD_MAX;
      end
      if (v < WORD_MIN) begin
         flag = 1'b1;
         return WORD_MIN;
      end
      return v;
   endfunction

   // Round half up from 2F to F fraction bits
   function automatic longint round_q(input longint v);
      return (v + HALF_LSB) >>> FRAC_BITS;
   endfunction

   // Sine and cosine in Q30 of a phase with F fraction bits
   function automatic void sin_cos_q30(input longint phase, output longint sin_v,
                                       output longint cos_v);
      longint rem;
      longint x;
      longint y;
      longint z;
      longint nx;
      bit     flip;
      // reduce to [-pi, pi), then fold the outer quadrants onto [-pi/2, pi/2]
      rem = (phase * PHASE_TO_G) % TWO_PI_G;
      if (rem < 0)
         rem += TWO_PI_G;
      if (rem >= PI_G)
         rem -= TWO_PI_G;
      flip = 1'b0;
      if (rem > HALF_PI_G) begin
         rem -= PI_G;
         flip = 1'b1;
      end else if (rem < -HALF_PI_G) begin
         rem += PI_G;
         flip = 1'b1;
      end
      z = rem >>> (FRAC_BITS - 2);
      x = CORDIC_START;
      y = 0;
      // rotate toward zero residual angle
      for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z  = z - atan_table[i];
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z  = z + atan_table[i];
         end
         x = nx;
      end
      sin_v = flip ? -y : y;
      cos_v = flip ? -x : x;
   endfunction

   function automatic curve_point_type predict_point(input longint t);
      curve_point_type pt;
      bit     clipped;
      longint phase;
      longint sin_v;
      longint cos_v;
      longint acc;
      clipped = 1'b0;
      phase = clip32(phase_off + round_q(t * rate), clipped);
      sin_cos_q30(phase, sin_v, cos_v);
      acc = base_r * phase - ((tracer_r * sin_v) >>> (30 - FRAC_BITS)) + x_off * ONE_F;
      pt.x = 32'(clip32(round_q(acc), clipped));
      acc = (y_off - base_r) * ONE_F + ((tracer_r * cos_v) >>> (30 - FRAC_BITS));
      pt.y = 32'(clip32(round_q(acc), clipped));
      pt.sat = clipped;
      return pt;
   endfunction

   always @(posedge clock) begin
      curve_point_type want;
      if (reset) begin
         base_r    = ONE_F;
         tracer_r  = ONE_F;
         x_off     = 0;
         y_off     = 0;
         phase_off = 0;
         rate      = ONE_F;
         point_queue.delete();
      end else begin
         // compare a finished point with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (point_queue.size() == 0) begin
               if (fails < 10)
                  $display("Unexpected point x=%h y=%h sat=%b", rsp_point_x, rsp_point_y,
                           rsp_saturated);
               fails++;
            end else begin
               want = point_queue.pop_front();
               checked++;
               if (rsp_point_x !== want.x || rsp_point_y !== want.y
                   || rsp_saturated !== want.sat) begin
                  if (fails < 10)
                     $display("Point mismatch: expected x=%h y=%h sat=%b, got x=%h y=%h sat=%b",
                              want.x, want.y, want.sat, rsp_point_x, rsp_point_y,
                              rsp_saturated);
                  fails++;
               end
            end
         end
         // predict the point of each accepted instant
         if (req_valid && req_ready)
            point_queue.insert(point_queue.size(), predict_point(longint'(req_instant)));
         // track register writes, drop unknown indexes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               tpg_pkg::CSR_BASE_RADIUS:   base_r    = longint'(signed'(csr_data));
               tpg_pkg::CSR_TRACER_RADIUS: tracer_r  = longint'(signed'(csr_data));
               tpg_pkg::CSR_X_OFFSET:      x_off     = longint'(signed'(csr_data));
               tpg_pkg::CSR_Y_OFFSET:      y_off     = longint'(signed'(csr_data));
               tpg_pkg::CSR_PHASE_OFFSET:  phase_off = longint'(signed'(csr_data));
               tpg_pkg::CSR_ROTATION_RATE: rate      = longint'(signed'(csr_data));
               default: ;
            endcase
         end
      end
      fail_count     <= fails;
      pending_points <= point_queue.size();
      checked_points <= checked;
   end

endmodule

// ===== test/tb_trochoid_point_generator.sv =====
// Testbench top of the trochoid point generator: stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb_trochoid_point_generator;

   localparam int FRAC_BITS     = 16;
   localparam int CORDIC_STAGES = 20;
   localparam int SETTLE_CYCLES = 60;
   localparam int STALL_LIMIT   = 2000;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_ITEMS   = 75;

   localparam logic [2:0]  CSR_SPARE_LO = 3'd6;
   localparam logic [2:0]  CSR_SPARE_HI = 3'd7;
   localparam logic [31:0] WORD_MAX     = 32'h7FFFFFFF;
   localparam logic [31:0] WORD_MIN     = 32'h80000000;
   localparam logic [31:0] ONE_Q        = 32'h00010000;

   typedef struct packed {
      logic [2:0]  index;
      logic [31:0] data;
   } reg_write_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic signed [31:0] req_instant;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [31:0] rsp_point_x;
   logic signed [31:0] rsp_point_y;
   logic               rsp_saturated;
   logic               csr_valid;
   logic               csr_ready;
   logic [2:0]         csr_index;
   logic [31:0]        csr_data;

   int fail_count;
   int pending_points;
   int checked_points;
   int instants_sent;
   int settings_applied;
   int idle_cycles;
   int req_stretch;
   int rsp_stretch;
   bit req_quiet;
   bit rsp_quiet;

   reg_write_type write_plan [$];

   // Instants around the quadrant and period borders at unit rate
   logic [31:0] border_instants [18] = '{
      32'd0, 32'd1, 32'hFFFFFFFF, WORD_MAX, WORD_MIN, ONE_Q, -ONE_Q, 32'h00008000,
      32'd102943, 32'd102944, -32'sd102943, -32'sd102944,
      32'd205887, 32'd205888, -32'sd205887, -32'sd205888, 32'd411774, 32'd411775
   };

   trochoid_point_generator #(
      .FRAC_BITS     (FRAC_BITS),
      .CORDIC_STAGES (CORDIC_STAGES)
   ) i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_instant   (req_instant),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_point_x   (rsp_point_x),
      .rsp_point_y   (rsp_point_y),
      .rsp_saturated (rsp_saturated),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   trochoid_point_checker #(
      .FRAC_BITS     (FRAC_BITS),
      .CORDIC_STAGES (CORDIC_STAGES)
   ) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_instant    (req_instant),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_point_x    (rsp_point_x),
      .rsp_point_y    (rsp_point_y),
      .rsp_saturated  (rsp_saturated),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .fail_count     (fail_count),
      .pending_points (pending_points),
      .checked_points (checked_points)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Gap before the next transaction; quiet stretches run back to back
   function automatic int draw_gap(inout int stretch, inout bit quiet);
      if (stretch == 0) begin
         stretch = $urandom_range(8, 48);
         quiet   = ($urandom_range(0, 3) == 0);
      end
      stretch--;
      return quiet ? 0 : $urandom_range(0, 11);
   endfunction

   // Mix of extremes, full-range words and values within +/- 2^span_bits
   function automatic logic [31:0] rand_word(input int span_bits);
      int pick;
      pick = $urandom_range(0, 15);
      if (pick < 2) begin
         case ($urandom_range(0, 6))
            0: return WORD_MIN;
            1: return WORD_MAX;
            2: return 32'd0;
            3: return 32'd1;
            4: return 32'hFFFFFFFF;
            5: return ONE_Q;
            default: return -ONE_Q;
         endcase
      end
      if (pick < 5)
         return $urandom;
      return 32'($urandom_range(0, (1 << (span_bits + 1)) - 1)) - (32'd1 << span_bits);
   endfunction

   function automatic void plan_write(input logic [2:0] index, input logic [31:0] data);
      reg_write_type w;
      w.index = index;
      w.data  = data;
      write_plan.insert(write_plan.size(), w);
   endfunction

   // Issue the planned register writes back to back, valid held high between them
   task automatic apply_writes();
      reg_write_type w;
      while (write_plan.size() != 0) begin
         w = write_plan.pop_front();
         csr_valid <= 1'b1;
         csr_index <= w.index;
         csr_data  <= w.data;
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      settings_applied++;
   endtask

   task automatic send_instant(input logic [31:0] value);
      int gap;
      gap = draw_gap(req_stretch, req_quiet);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_instant <= value;
      do @(posedge clock); while (!req_ready);
      instants_sent++;
   endtask

   // Stop sending and wait until every predicted point has come back
   task automatic drain_points();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_points != 0);
   endtask

   // Result side: stall a random number of cycles before each transaction
   initial begin
      int gap;
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         gap = draw_gap(rsp_stretch, rsp_quiet);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Abort when no channel has moved a transaction for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
         $display("No transaction for %0d cycles, %0d points outstanding", STALL_LIMIT,
                  pending_points);
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_instant <= '0;
      csr_valid   <= 1'b0;
      csr_index   <= '0;
      csr_data    <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset settings: borders of the phase reduction and field extremes
      foreach (border_instants[n])
         send_instant(border_instants[n]);
      drain_points();

      // most positive values, y_offset most negative, spare indexes written too
      plan_write(tpg_pkg::CSR_BASE_RADIUS, WORD_MAX);
      plan_write(tpg_pkg::CSR_TRACER_RADIUS, WORD_MAX);
      plan_write(CSR_SPARE_LO, 32'hA5A5A5A5);
      plan_write(tpg_pkg::CSR_X_OFFSET, WORD_MAX);
      plan_write(tpg_pkg::CSR_Y_OFFSET, WORD_MIN);
      plan_write(tpg_pkg::CSR_PHASE_OFFSET, WORD_MAX);
      plan_write(tpg_pkg::CSR_ROTATION_RATE, WORD_MAX);
      plan_write(CSR_SPARE_HI, 32'h5A5A5A5A);
      apply_writes();
      send_instant(WORD_MAX);
      send_instant(WORD_MIN);
      send_instant(32'd0);
      send_instant(32'hFFFFFFFF);
      drain_points();

      // most negative values, y_offset most positive
      plan_write(tpg_pkg::CSR_BASE_RADIUS, WORD_MIN);
      plan_write(tpg_pkg::CSR_TRACER_RADIUS, WORD_MIN);
      plan_write(tpg_pkg::CSR_X_OFFSET, WORD_MIN);
      plan_write(tpg_pkg::CSR_Y_OFFSET, WORD_MAX);
      plan_write(tpg_pkg::CSR_PHASE_OFFSET, WORD_MIN);
      plan_write(tpg_pkg::CSR_ROTATION_RATE, WORD_MIN);
      apply_writes();
      send_instant(WORD_MAX);
      send_instant(WORD_MIN);
      send_instant(32'd1);
      drain_points();

      // random curves, each followed by a stream of random instants
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         plan_write(tpg_pkg::CSR_BASE_RADIUS, rand_word(20));
         plan_write(tpg_pkg::CSR_TRACER_RADIUS, rand_word(20));
         plan_write(tpg_pkg::CSR_X_OFFSET, rand_word(26));
         plan_write(tpg_pkg::CSR_Y_OFFSET, rand_word(26));
         plan_write(tpg_pkg::CSR_PHASE_OFFSET, rand_word(19));
         plan_write(tpg_pkg::CSR_ROTATION_RATE, rand_word(19));
         if ($urandom_range(0, 3) == 0)
            plan_write($urandom_range(0, 1) ? CSR_SPARE_HI : CSR_SPARE_LO, $urandom);
         apply_writes();
         repeat (PHASE_ITEMS)
            send_instant(rand_word(22));
         drain_points();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d instants over %0d register settings, clipping and quadrant borders",
               instants_sent, settings_applied);
      $display("included; %0d points compared with the prediction.", checked_points);
      if (fail_count == 0 && pending_points == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/tpg_pkg.sv
hw/rtl/tpg_reduce_cell.sv
hw/rtl/tpg_cordic_cell.sv
hw/rtl/trochoid_point_generator.sv
hw/rtl/tpg_checker.sv
test/trochoid_point_checker.sv
test/tb_trochoid_point_generator.sv
